>>> hw/rtl/imu_sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Types and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
package imu_sfp_pkg;

   localparam int StoreDepth = 24;
   localparam int WordCount  = 6;
   localparam int ByteWidth  = 8;
   localparam int WordWidth  = 32;

   localparam logic [ByteWidth-1:0] CountMax = 8'd255;

   localparam logic [1:0] CsrHeaderByte  = 2'd0;
   localparam logic [1:0] CsrEndByte     = 2'd1;
   localparam logic [1:0] CsrImuCommand  = 2'd2;
   localparam logic [1:0] CsrAhrsCommand = 2'd3;

   localparam logic [ByteWidth-1:0] HeaderByteReset  = 8'd252;
   localparam logic [ByteWidth-1:0] EndByteReset     = 8'd253;
   localparam logic [ByteWidth-1:0] ImuCommandReset  = 8'd64;
   localparam logic [ByteWidth-1:0] AhrsCommandReset = 8'd65;

   localparam logic KindImu  = 1'b0;
   localparam logic KindAhrs = 1'b1;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_COMMAND,
      PH_LENGTH,
      PH_SEQUENCE,
      PH_CRC8,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_DATA,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] header_byte;
      logic [ByteWidth-1:0] end_byte;
      logic [ByteWidth-1:0] imu_command;
      logic [ByteWidth-1:0] ahrs_command;
   } csr_type;

   typedef struct packed {
      logic                                frame_kind;
      logic [ByteWidth-1:0]                sequence_number;
      logic [WordCount-1:0][WordWidth-1:0] words;
   } result_type;

endpackage

>>> hw/rtl/imu_sfp_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser channels
// Valid/ready channels for received bytes and for parsed frames.
// ----------------------------------------------------------------------------
interface imu_sfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface imu_sfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_kind;
   logic [7:0]  sequence_number;
   logic [31:0] word_zero;
   logic [31:0] word_one;
   logic [31:0] word_two;
   logic [31:0] word_three;
   logic [31:0] word_four;
   logic [31:0] word_five;

   modport source (output valid, output frame_kind, output sequence_number,
                   output word_zero, output word_one, output word_two,
                   output word_three, output word_four, output word_five,
                   input ready);
   modport sink (input valid, input frame_kind, input sequence_number,
                 input word_zero, input word_one, input word_two,
                 input word_three, input word_four, input word_five,
                 output ready);
endinterface

>>> hw/rtl/imu_sfp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser registers
// Holds the header, end and command byte values written over the CSR port.
// ----------------------------------------------------------------------------
module imu_sfp_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_write_data,
   output imu_sfp_pkg::csr_type  csr
);

   imu_sfp_pkg::csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.header_byte  <= imu_sfp_pkg::HeaderByteReset;
         csr_ff.end_byte     <= imu_sfp_pkg::EndByteReset;
         csr_ff.imu_command  <= imu_sfp_pkg::ImuCommandReset;
         csr_ff.ahrs_command <= imu_sfp_pkg::AhrsCommandReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            imu_sfp_pkg::CsrHeaderByte:  csr_ff.header_byte  <= csr_write_data;
            imu_sfp_pkg::CsrEndByte:     csr_ff.end_byte     <= csr_write_data;
            imu_sfp_pkg::CsrImuCommand:  csr_ff.imu_command  <= csr_write_data;
            imu_sfp_pkg::CsrAhrsCommand: csr_ff.ahrs_command <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign csr = csr_ff;

endmodule

>>> hw/rtl/imu_sfp_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser input stage
// Registers one received byte and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module imu_sfp_input_stage (
   input  logic              clock,
   input  logic              reset,
   imu_sfp_req_if.sink       req_chan,
   input  logic              take,
   output logic              in_valid,
   output logic [7:0]        in_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;
   assign valid_in       = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

>>> hw/rtl/imu_sfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser state machine
// Walks the frame one byte at a time, keeps the first payload bytes and
// builds the result when a correct end byte closes the frame.
// ----------------------------------------------------------------------------
module imu_sfp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [7:0]               in_byte,
   input  imu_sfp_pkg::csr_type     csr,
   input  logic                     out_free,
   output logic                     take,
   output logic                     push,
   output imu_sfp_pkg::result_type  result
);

   imu_sfp_pkg::phase_type phase_ff;
   imu_sfp_pkg::phase_type phase_in;
   logic [7:0]             command_ff;
   logic [7:0]             command_in;
   logic [7:0]             length_ff;
   logic [7:0]             length_in;
   logic [7:0]             sequence_ff;
   logic [7:0]             sequence_in;
   logic [7:0]             count_ff;
   logic [7:0]             count_in;
   logic [7:0]             count_step;
   logic                   store_write;
   logic                   emit;
   logic                   kind;

   logic [imu_sfp_pkg::StoreDepth-1:0][7:0] store_ff;

   assign take = in_valid && (out_free || !emit);
   assign push = take && emit;

   always_comb begin
      phase_in    = phase_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      sequence_in = sequence_ff;
      count_in    = count_ff;
      store_write = 1'b0;
      emit        = 1'b0;
      kind        = imu_sfp_pkg::KindImu;
      count_step  = (count_ff == imu_sfp_pkg::CountMax) ? count_ff : count_ff + 8'd1;
      unique case (phase_ff)
         imu_sfp_pkg::PH_HEADER: begin
            if (in_byte == csr.header_byte) begin
               phase_in = imu_sfp_pkg::PH_COMMAND;
            end
         end
         imu_sfp_pkg::PH_COMMAND: begin
            if (in_byte == csr.imu_command || in_byte == csr.ahrs_command) begin
               command_in = in_byte;
               phase_in   = imu_sfp_pkg::PH_LENGTH;
            end else begin
               phase_in = imu_sfp_pkg::PH_HEADER;
            end
         end
         imu_sfp_pkg::PH_LENGTH: begin
            length_in = in_byte;
            count_in  = 8'd0;
            phase_in  = imu_sfp_pkg::PH_SEQUENCE;
         end
         imu_sfp_pkg::PH_SEQUENCE: begin
            sequence_in = in_byte;
            phase_in    = imu_sfp_pkg::PH_CRC8;
         end
         imu_sfp_pkg::PH_CRC8:   phase_in = imu_sfp_pkg::PH_CRC_LO;
         imu_sfp_pkg::PH_CRC_LO: phase_in = imu_sfp_pkg::PH_CRC_HI;
         imu_sfp_pkg::PH_CRC_HI: phase_in = imu_sfp_pkg::PH_DATA;
         imu_sfp_pkg::PH_DATA: begin
            store_write = count_ff < 8'(imu_sfp_pkg::StoreDepth);
            count_in    = count_step;
            if (count_step >= length_ff) begin
               phase_in = imu_sfp_pkg::PH_END;
            end
         end
         imu_sfp_pkg::PH_END: begin
            if (in_byte == csr.end_byte) begin
               if (command_ff == csr.imu_command) begin
                  emit = 1'b1;
                  kind = imu_sfp_pkg::KindImu;
               end else if (command_ff == csr.ahrs_command) begin
                  emit = 1'b1;
                  kind = imu_sfp_pkg::KindAhrs;
               end
            end
            phase_in = imu_sfp_pkg::PH_HEADER;
         end
         default: phase_in = imu_sfp_pkg::PH_HEADER;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= imu_sfp_pkg::PH_HEADER;
         command_ff  <= 8'd0;
         length_ff   <= 8'd0;
         sequence_ff <= 8'd0;
         count_ff    <= 8'd0;
      end else if (take) begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         sequence_ff <= sequence_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
      end else if (take && store_write) begin
         store_ff[count_ff[4:0]] <= in_byte;
      end
   end

   assign result.frame_kind      = kind;
   assign result.sequence_number = sequence_ff;
   assign result.words           = store_ff;

endmodule

>>> hw/rtl/imu_sfp_output_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser output stage
// Holds one parsed frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module imu_sfp_output_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  imu_sfp_pkg::result_type  result,
   output logic                     out_free,
   imu_sfp_rsp_if.source            rsp_chan
);

   logic                    valid_ff;
   logic                    valid_in;
   imu_sfp_pkg::result_type result_ff;

   assign out_free = !valid_ff || rsp_chan.ready;
   assign valid_in = push || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.frame_kind      = result_ff.frame_kind;
   assign rsp_chan.sequence_number = result_ff.sequence_number;
   assign rsp_chan.word_zero       = result_ff.words[0];
   assign rsp_chan.word_one        = result_ff.words[1];
   assign rsp_chan.word_two        = result_ff.words[2];
   assign rsp_chan.word_three      = result_ff.words[3];
   assign rsp_chan.word_four       = result_ff.words[4];
   assign rsp_chan.word_five       = result_ff.words[5];

endmodule

>>> hw/rtl/imu_serial_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser
// Takes one received byte per item and reports each complete IMU or AHRS
// frame as its kind, sequence number and six little-endian payload words.
// The block accepts one byte per clock cycle unless a stall holds it. A byte
// is registered on acceptance and parsed when the parser takes it, so a
// frame's result is registered as the parser takes its end byte. The output
// register holds one result; while it waits, later bytes are still taken and
// parsed, and only a byte that would itself complete a frame stalls, which
// then holds the input register full. Header CRC bytes are skipped
// unchecked, and only the first 24 payload bytes are kept.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser (
   input  logic          clock,
   input  logic          reset,
   imu_sfp_req_if.sink   req_chan,
   imu_sfp_rsp_if.source rsp_chan,
   input  logic          csr_write_enable,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_write_data
);

   imu_sfp_pkg::csr_type    csr;
   imu_sfp_pkg::result_type result;
   logic                    in_valid;
   logic [7:0]              in_byte;
   logic                    take;
   logic                    push;
   logic                    out_free;

   imu_sfp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   imu_sfp_input_stage u_input_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_valid (in_valid),
      .in_byte  (in_byte)
   );

   imu_sfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_byte  (in_byte),
      .csr      (csr),
      .out_free (out_free),
      .take     (take),
      .push     (push),
      .result   (result)
   );

   imu_sfp_output_stage u_output_stage (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU serial frame parser testbench
// Drives received bytes into the parser and checks every reported frame
// against a predictor that walks the same frame layout. It runs directed
// frames for each corner of the layout, then random traffic under changing
// header, end and command settings, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CycleLimit   = 500000;
   localparam int SettleCycles = 8;
   localparam int RandomItems  = 300;
   localparam int HoldCycles   = 300;

   typedef enum int {
      ReceiverOpen,
      ReceiverRandom,
      ReceiverPattern
   } receiver_mode_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   imu_sfp_req_if req_bus ();
   imu_sfp_rsp_if rsp_bus ();

   imu_serial_frame_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   imu_sfp_pkg::csr_type    cfg;
   imu_sfp_pkg::phase_type  parse_phase;
   logic [7:0]              saved_command;
   logic [7:0]              frame_length;
   logic [7:0]              saved_sequence;
   logic [7:0]              payload_count;
   logic [7:0]              payload_bytes [imu_sfp_pkg::StoreDepth];
   imu_sfp_pkg::result_type expected_frames [$];
   int                      error_count = 0;
   int                      cycle_count = 0;

   logic [7:0]        frame_bytes [$];
   bit                pace_on = 1'b0;
   int                burst_left = 0;
   receiver_mode_type receiver_mode = ReceiverOpen;
   int                hold_cycles = 0;
   int                stall_step = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void reset_predictor();
      cfg.header_byte  = imu_sfp_pkg::HeaderByteReset;
      cfg.end_byte     = imu_sfp_pkg::EndByteReset;
      cfg.imu_command  = imu_sfp_pkg::ImuCommandReset;
      cfg.ahrs_command = imu_sfp_pkg::AhrsCommandReset;
      parse_phase      = imu_sfp_pkg::PH_HEADER;
      saved_command    = '0;
      frame_length     = '0;
      saved_sequence   = '0;
      payload_count    = '0;
      for (int i = 0; i < imu_sfp_pkg::StoreDepth; i++) payload_bytes[i] = '0;
   endfunction

   function automatic void parse_byte(input logic [7:0] value);
      imu_sfp_pkg::result_type frame;
      case (parse_phase)
         imu_sfp_pkg::PH_HEADER: begin
            if (value == cfg.header_byte) parse_phase = imu_sfp_pkg::PH_COMMAND;
         end
         imu_sfp_pkg::PH_COMMAND: begin
            if (value == cfg.imu_command || value == cfg.ahrs_command) begin
               saved_command = value;
               parse_phase   = imu_sfp_pkg::PH_LENGTH;
            end else begin
               parse_phase = imu_sfp_pkg::PH_HEADER;
            end
         end
         imu_sfp_pkg::PH_LENGTH: begin
            frame_length  = value;
            payload_count = '0;
            parse_phase   = imu_sfp_pkg::PH_SEQUENCE;
         end
         imu_sfp_pkg::PH_SEQUENCE: begin
            saved_sequence = value;
            parse_phase    = imu_sfp_pkg::PH_CRC8;
         end
         imu_sfp_pkg::PH_CRC8: parse_phase = imu_sfp_pkg::PH_CRC_LO;
         imu_sfp_pkg::PH_CRC_LO: parse_phase = imu_sfp_pkg::PH_CRC_HI;
         imu_sfp_pkg::PH_CRC_HI: parse_phase = imu_sfp_pkg::PH_DATA;
         imu_sfp_pkg::PH_DATA: begin
            if (payload_count < imu_sfp_pkg::StoreDepth) begin
               payload_bytes[payload_count] = value;
            end
            if (payload_count != imu_sfp_pkg::CountMax) payload_count++;
            if (payload_count >= frame_length) parse_phase = imu_sfp_pkg::PH_END;
         end
         imu_sfp_pkg::PH_END: begin
            if (value == cfg.end_byte && (saved_command == cfg.imu_command ||
                                          saved_command == cfg.ahrs_command)) begin
               frame.frame_kind = (saved_command == cfg.imu_command) ?
                                  imu_sfp_pkg::KindImu : imu_sfp_pkg::KindAhrs;
               frame.sequence_number = saved_sequence;
               for (int k = 0; k < imu_sfp_pkg::WordCount; k++) begin
                  frame.words[k] = {payload_bytes[4*k+3], payload_bytes[4*k+2],
                                    payload_bytes[4*k+1], payload_bytes[4*k]};
               end
               expected_frames.push_back(frame);
            end
            parse_phase = imu_sfp_pkg::PH_HEADER;
         end
         default: parse_phase = imu_sfp_pkg::PH_HEADER;
      endcase
   endfunction

   task automatic report_mismatch(input string message);
      error_count++;
      $display("[%0t] mismatch: %s", $time, message);
   endtask

   task automatic check_frame();
      imu_sfp_pkg::result_type seen;
      imu_sfp_pkg::result_type want;
      seen.frame_kind      = rsp_bus.frame_kind;
      seen.sequence_number = rsp_bus.sequence_number;
      seen.words[0]        = rsp_bus.word_zero;
      seen.words[1]        = rsp_bus.word_one;
      seen.words[2]        = rsp_bus.word_two;
      seen.words[3]        = rsp_bus.word_three;
      seen.words[4]        = rsp_bus.word_four;
      seen.words[5]        = rsp_bus.word_five;
      if (expected_frames.size() == 0) begin
         report_mismatch($sformatf("frame with sequence %0d was not expected",
                                   seen.sequence_number));
      end else begin
         want = expected_frames.pop_front();
         if (seen.frame_kind !== want.frame_kind) begin
            report_mismatch($sformatf("frame kind: expected %b, got %b",
                                      want.frame_kind, seen.frame_kind));
         end
         if (seen.sequence_number !== want.sequence_number) begin
            report_mismatch($sformatf("sequence number: expected %h, got %h",
                                      want.sequence_number, seen.sequence_number));
         end
         for (int k = 0; k < imu_sfp_pkg::WordCount; k++) begin
            if (seen.words[k] !== want.words[k]) begin
               report_mismatch($sformatf("word %0d: expected %h, got %h",
                                         k, want.words[k], seen.words[k]));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) parse_byte(req_bus.rx_byte);
         if (rsp_bus.valid && rsp_bus.ready) check_frame();
      end
   end

   always @(negedge clock) begin
      stall_step++;
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles--;
      end else begin
         case (receiver_mode)
            ReceiverRandom: rsp_bus.ready <= ($urandom_range(0, 99) < 60);
            ReceiverPattern: rsp_bus.ready <= ((stall_step % 7) >= 3);
            default: rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] value);
      if (pace_on) begin
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = $urandom_range(1, 20);
         end else begin
            burst_left--;
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_prefix(input int count);
      for (int i = 0; i < count; i++) send_byte(frame_bytes[i]);
   endtask

   task automatic compose_frame(input logic [7:0] head, input logic [7:0] command,
                                input int length, input logic [7:0] sequence_byte,
                                input int fill, input logic [7:0] tail);
      int count;
      count = (length == 0) ? 1 : length;
      frame_bytes.delete();
      frame_bytes.push_back(head);
      frame_bytes.push_back(command);
      frame_bytes.push_back(length[7:0]);
      frame_bytes.push_back(sequence_byte);
      repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
      repeat (count) begin
         frame_bytes.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
      end
      frame_bytes.push_back(tail);
   endtask

   task automatic send_frame(input logic [7:0] command, input int length, input int fill);
      compose_frame(cfg.header_byte, command, length, 8'($urandom_range(0, 255)), fill,
                    cfg.end_byte);
      send_prefix(frame_bytes.size());
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_frames.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         imu_sfp_pkg::CsrHeaderByte: cfg.header_byte = value;
         imu_sfp_pkg::CsrEndByte: cfg.end_byte = value;
         imu_sfp_pkg::CsrImuCommand: cfg.imu_command = value;
         imu_sfp_pkg::CsrAhrsCommand: cfg.ahrs_command = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] head, input logic [7:0] tail,
                            input logic [7:0] imu, input logic [7:0] ahrs);
      write_register(imu_sfp_pkg::CsrHeaderByte, head);
      write_register(imu_sfp_pkg::CsrEndByte, tail);
      write_register(imu_sfp_pkg::CsrImuCommand, imu);
      write_register(imu_sfp_pkg::CsrAhrsCommand, ahrs);
   endtask

   task automatic test_basic_frames();
      send_frame(cfg.imu_command, imu_sfp_pkg::StoreDepth, 8'hFF);
      send_frame(cfg.ahrs_command, imu_sfp_pkg::StoreDepth, 8'h00);
      compose_frame(cfg.header_byte, cfg.imu_command, imu_sfp_pkg::StoreDepth, 8'h00, -1,
                    cfg.end_byte);
      send_prefix(frame_bytes.size());
      compose_frame(cfg.header_byte, cfg.ahrs_command, imu_sfp_pkg::StoreDepth, 8'hFF, -1,
                    cfg.end_byte);
      send_prefix(frame_bytes.size());
      wait_idle();
   endtask

   task automatic test_bad_command();
      // A rejected command byte equal to the header must not restart a frame.
      send_byte(cfg.header_byte);
      send_byte(cfg.header_byte);
      send_byte(cfg.imu_command);
      send_frame(cfg.imu_command, 8, -1);
      send_byte(cfg.header_byte);
      send_byte(8'h00);
      send_frame(cfg.ahrs_command, 4, -1);
      wait_idle();
   endtask

   task automatic test_payload_lengths();
      send_frame(cfg.ahrs_command, 0, -1);
      send_frame(cfg.imu_command, 3, -1);
      send_frame(cfg.imu_command, 30, -1);
      send_frame(cfg.ahrs_command, 255, -1);
      send_frame(cfg.imu_command, 1, -1);
      wait_idle();
   endtask

   task automatic test_end_byte();
      compose_frame(cfg.header_byte, cfg.imu_command, 6, 8'h5A, -1, cfg.end_byte ^ 8'h01);
      send_prefix(frame_bytes.size());
      send_frame(cfg.ahrs_command, 6, -1);
      compose_frame(cfg.header_byte, cfg.ahrs_command, 2, 8'hA5, -1, cfg.header_byte);
      send_prefix(frame_bytes.size());
      send_frame(cfg.imu_command, 2, -1);
      wait_idle();
   endtask

   task automatic test_command_change();
      // The frame kind is settled only when the end byte arrives.
      send_frame(cfg.imu_command, 2, -1);
      compose_frame(cfg.header_byte, cfg.imu_command, 4, 8'h11, -1, cfg.end_byte);
      send_prefix(frame_bytes.size() - 1);
      wait_idle();
      write_register(imu_sfp_pkg::CsrImuCommand, 8'd70);
      send_byte(cfg.end_byte);
      wait_idle();
      write_register(imu_sfp_pkg::CsrImuCommand, imu_sfp_pkg::ImuCommandReset);

      compose_frame(cfg.header_byte, cfg.ahrs_command, 5, 8'h22, -1, cfg.end_byte);
      send_prefix(frame_bytes.size() - 1);
      wait_idle();
      write_register(imu_sfp_pkg::CsrImuCommand, imu_sfp_pkg::AhrsCommandReset);
      send_byte(cfg.end_byte);
      wait_idle();
      write_register(imu_sfp_pkg::CsrImuCommand, imu_sfp_pkg::ImuCommandReset);

      compose_frame(cfg.header_byte, cfg.imu_command, 6, 8'h33, -1, cfg.end_byte);
      send_prefix(frame_bytes.size() - 1);
      wait_idle();
      write_register(imu_sfp_pkg::CsrImuCommand, 8'd66);
      write_register(imu_sfp_pkg::CsrAhrsCommand, imu_sfp_pkg::ImuCommandReset);
      send_byte(cfg.end_byte);
      wait_idle();
      configure(imu_sfp_pkg::HeaderByteReset, imu_sfp_pkg::EndByteReset,
                imu_sfp_pkg::ImuCommandReset, imu_sfp_pkg::AhrsCommandReset);
   endtask

   task automatic test_register_extremes();
      configure(8'h00, 8'hFF, 8'h00, 8'hFF);
      send_frame(cfg.imu_command, 5, -1);
      send_frame(cfg.ahrs_command, 0, -1);
      wait_idle();
      configure(8'hFF, 8'h00, 8'hFF, 8'h00);
      send_frame(cfg.imu_command, 4, -1);
      send_frame(cfg.ahrs_command, 7, -1);
      wait_idle();
      // With both command registers equal, the frame counts as IMU.
      configure(imu_sfp_pkg::HeaderByteReset, imu_sfp_pkg::EndByteReset, 8'd90, 8'd90);
      send_frame(8'd90, 3, -1);
      wait_idle();
      configure(imu_sfp_pkg::HeaderByteReset, imu_sfp_pkg::EndByteReset,
                imu_sfp_pkg::ImuCommandReset, imu_sfp_pkg::AhrsCommandReset);
   endtask

   task automatic test_backpressure();
      pace_on       = 1'b0;
      receiver_mode = ReceiverOpen;
      @(posedge clock);
      hold_cycles = HoldCycles;
      @(negedge clock);
      repeat (12) begin
         send_frame($urandom_range(0, 1) ? cfg.ahrs_command : cfg.imu_command,
                    $urandom_range(0, 2), -1);
      end
      wait_idle();
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return $urandom_range(0, 28);
      if (roll < 97) return $urandom_range(29, 64);
      return $urandom_range(65, 255);
   endfunction

   task automatic send_random_event(inout int counted);
      int         roll;
      int         cut;
      logic [7:0] command;
      logic [7:0] tail;
      roll    = $urandom_range(0, 99);
      command = $urandom_range(0, 1) ? cfg.ahrs_command : cfg.imu_command;
      tail    = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : cfg.end_byte;
      if (roll < 75) begin
         compose_frame(cfg.header_byte, command, pick_length(),
                       8'($urandom_range(0, 255)), -1, tail);
         send_prefix(frame_bytes.size());
         counted += frame_bytes.size();
      end else if (roll < 85) begin
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (roll < 92) begin
         command = 8'($urandom_range(0, 255));
         while (command == cfg.imu_command || command == cfg.ahrs_command) begin
            command = 8'($urandom_range(0, 255));
         end
         send_byte(cfg.header_byte);
         send_byte(command);
         counted += 2;
      end else begin
         compose_frame(cfg.header_byte, command, pick_length(),
                       8'($urandom_range(0, 255)), -1, tail);
         cut = $urandom_range(1, frame_bytes.size() - 1);
         send_prefix(cut);
         counted += cut;
      end
   endtask

   task automatic test_random_traffic();
      int counted;
      int round;
      counted = 0;
      round   = 0;
      while (counted < RandomItems) begin
         wait_idle();
         case (round)
            0: configure(imu_sfp_pkg::HeaderByteReset, imu_sfp_pkg::EndByteReset,
                         imu_sfp_pkg::ImuCommandReset, imu_sfp_pkg::AhrsCommandReset);
            1: configure(8'h00, 8'hFF, 8'h00, 8'hFF);
            2: configure(8'hFF, 8'h00, 8'hFF, 8'h00);
            default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         pace_on       = (round % 4) != 0;
         receiver_mode = receiver_mode_type'(round % 3);
         while (counted < (round + 1) * (RandomItems / 6)) send_random_event(counted);
         round++;
      end
      wait_idle();
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = '0;
      rsp_bus.ready    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      reset_predictor();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_frames();
      test_bad_command();
      test_payload_lengths();
      test_end_byte();
      test_command_change();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      repeat (SettleCycles) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
